[design/bfiq_pkg.sv]
// Package for the Bloom filter insert and query unit.
// Holds the fixed field widths, register codes, sequencer states and control structs.
// No dependencies.
package bfiq_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned NUM_WORDS = 5;
  localparam int unsigned COUNT_W   = 17;
  localparam int unsigned CFG_W     = 3;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic             REG_HASH_COUNT = 1'b0;
  localparam logic [CFG_W-1:0] HASH_COUNT_RST = 3'd5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    SEQ_CLEAR,
    SEQ_IDLE,
    SEQ_READ,
    SEQ_CHECK,
    SEQ_DONE
  } seq_state_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wdata;
  } mem_ctl_t;

  typedef struct packed {
    logic clear_busy;
  } mem_status_t;

endpackage

[design/bfiq_mod_reduce.sv]
// Four-stage pipeline that reduces a 32-bit hash word modulo the filter size.
// Uses a reciprocal multiply, a multiply back and one correction step.
// Depends on bfiq_pkg.
module bfiq_mod_reduce #(
  parameter int FILTER_SIZE = 65536,
  parameter int IDX_W       = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [bfiq_pkg::WORD_W-1:0] word_i,
  output logic                       valid_o,
  output logic [IDX_W-1:0]           index_o
);

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(FILTER_SIZE));
  localparam logic [IDX_W:0] SIZE_W = (IDX_W+1)'(FILTER_SIZE);

  logic [3:0]       valid_q;
  logic [63:0]      prod1;
  logic [31:0]      qest_q;
  logic [IDX_W:0]   wlo1_q, wlo2_q;
  logic [IDX_W:0]   prod2_q;
  logic [IDX_W:0]   rem_q;
  logic [IDX_W:0]   rem_fix;
  logic [IDX_W-1:0] index_q;

  assign prod1   = 64'(word_i) * 64'(RECIP);
  assign rem_fix = (rem_q >= SIZE_W) ? (rem_q - SIZE_W) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    qest_q  <= prod1[63:32];
    wlo1_q  <= word_i[IDX_W:0];
    prod2_q <= (IDX_W+1)'(qest_q[IDX_W:0] * SIZE_W);
    wlo2_q  <= wlo1_q;
    rem_q   <= wlo2_q - prod2_q;
    index_q <= rem_fix[IDX_W-1:0];
  end

  assign valid_o = valid_q[3];
  assign index_o = index_q;

endmodule

[design/bfiq_bit_store.sv]
// Single-port filter bit memory with a registered read.
// Sweeps every entry to zero after reset before reporting ready. Depends on bfiq_pkg.
module bfiq_bit_store #(
  parameter int FILTER_SIZE = 65536,
  parameter int IDX_W       = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bfiq_pkg::mem_ctl_t    ctl_i,
  input  logic [IDX_W-1:0]      addr_i,
  output logic                  rdata_o,
  output bfiq_pkg::mem_status_t status_o
);

  localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(FILTER_SIZE - 1);

  logic             mem_q [FILTER_SIZE];
  logic             rdata_q;
  logic [IDX_W-1:0] sweep_q;
  logic             busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
      busy_q  <= 1'b1;
    end else if (busy_q) begin
      sweep_q <= sweep_q + 1'b1;
      if (sweep_q == LAST_ADDR) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[sweep_q] <= 1'b0;
    end else if (ctl_i.wr_en) begin
      mem_q[addr_i] <= ctl_i.wdata;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o             = rdata_q;
  assign status_o.clear_busy = busy_q;

endmodule

[design/bloom_filter_insert_query_unit.sv]
// Top level of the Bloom filter insert and query unit.
// Instantiates bfiq_mod_reduce and bfiq_bit_store; depends on bfiq_pkg.
//
// After reset the unit clears its bit memory one entry per cycle, and stalls input until
// that is done. Each item then uses k hash words, where k is the effective hash count:
// a four-stage modulo pipeline turns the hash words into bit indices, and the single
// memory port reads each indexed bit in the READ state and then checks or sets it in the
// CHECK state. A finished result waits in an output register, so the next item is taken while
// the previous result is still stalled. Items with k of zero return present with no change.
module bloom_filter_insert_query_unit #(
  parameter int FILTER_SIZE = 65536,
  parameter int MAX_HASHES  = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bfiq_pkg::APB_AW-1:0]         paddr,
  input  logic [bfiq_pkg::APB_DW-1:0]         pwdata,
  output logic [bfiq_pkg::APB_DW-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                operation_i,
  input  logic [bfiq_pkg::WORD_W-1:0]         hash_word_0_i,
  input  logic [bfiq_pkg::WORD_W-1:0]         hash_word_1_i,
  input  logic [bfiq_pkg::WORD_W-1:0]         hash_word_2_i,
  input  logic [bfiq_pkg::WORD_W-1:0]         hash_word_3_i,
  input  logic [bfiq_pkg::WORD_W-1:0]         hash_word_4_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                present_o,
  output logic [bfiq_pkg::COUNT_W-1:0]        ones_total_o
);

  localparam int IDX_W = $clog2(FILTER_SIZE);
  localparam int CNT_W = $clog2(MAX_HASHES + 1);
  localparam int SEL_W = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;

  bfiq_pkg::seq_state_e state_q, state_d;

  logic [bfiq_pkg::CFG_W-1:0]   hash_count_q;
  logic                         cfg_write;
  logic [bfiq_pkg::WORD_W-1:0]  in_words [bfiq_pkg::NUM_WORDS];
  logic [bfiq_pkg::WORD_W-1:0]  words_q [MAX_HASHES];
  logic [IDX_W-1:0]             idx_q [MAX_HASHES];
  logic                         op_q;
  logic [CNT_W-1:0]             k_q, k_new;
  logic [CNT_W-1:0]             feed_q, red_q, ptr_q;
  logic                         all_hit_q;
  logic [bfiq_pkg::COUNT_W-1:0] count_q;
  logic                         out_valid_q, present_q;
  logic [bfiq_pkg::COUNT_W-1:0] ones_q;

  logic                         accept, feed_valid, red_valid, rd_bit, last_word, out_load;
  logic                         word_ready;
  logic [IDX_W-1:0]             red_index;
  bfiq_pkg::mem_ctl_t           mem_ctl;
  bfiq_pkg::mem_status_t        mem_st;

  assign in_words[0] = hash_word_0_i;
  assign in_words[1] = hash_word_1_i;
  assign in_words[2] = hash_word_2_i;
  assign in_words[3] = hash_word_3_i;
  assign in_words[4] = hash_word_4_i;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      bfiq_pkg::REG_HASH_COUNT: prdata = bfiq_pkg::APB_DW'(hash_count_q);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_count_q <= bfiq_pkg::HASH_COUNT_RST;
    end else if (cfg_write && paddr[2] == bfiq_pkg::REG_HASH_COUNT) begin
      hash_count_q <= pwdata[bfiq_pkg::CFG_W-1:0];
    end
  end

  assign k_new = (hash_count_q > bfiq_pkg::CFG_W'(MAX_HASHES)) ? CNT_W'(MAX_HASHES)
                                                                 : CNT_W'(hash_count_q);

  assign accept     = (state_q == bfiq_pkg::SEQ_IDLE) && in_valid_i;
  assign feed_valid = (state_q != bfiq_pkg::SEQ_IDLE) && (state_q != bfiq_pkg::SEQ_CLEAR)
                      && (feed_q < k_q);
  assign word_ready = red_q > ptr_q;
  assign last_word  = (ptr_q + 1'b1) == k_q;
  assign out_load   = (state_q == bfiq_pkg::SEQ_DONE) && (!out_valid_q || !out_stall_i);

  bfiq_mod_reduce #(
    .FILTER_SIZE (FILTER_SIZE),
    .IDX_W       (IDX_W)
  ) u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (feed_valid),
    .word_i  (words_q[feed_q[SEL_W-1:0]]),
    .valid_o (red_valid),
    .index_o (red_index)
  );

  bfiq_bit_store #(
    .FILTER_SIZE (FILTER_SIZE),
    .IDX_W       (IDX_W)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mem_ctl),
    .addr_i   (idx_q[ptr_q[SEL_W-1:0]]),
    .rdata_o  (rd_bit),
    .status_o (mem_st)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfiq_pkg::SEQ_CLEAR: if (!mem_st.clear_busy) state_d = bfiq_pkg::SEQ_IDLE;
      bfiq_pkg::SEQ_IDLE: begin
        if (in_valid_i) begin
          state_d = (k_new == '0) ? bfiq_pkg::SEQ_DONE : bfiq_pkg::SEQ_READ;
        end
      end
      bfiq_pkg::SEQ_READ:  if (word_ready) state_d = bfiq_pkg::SEQ_CHECK;
      bfiq_pkg::SEQ_CHECK: state_d = last_word ? bfiq_pkg::SEQ_DONE : bfiq_pkg::SEQ_READ;
      bfiq_pkg::SEQ_DONE:  if (out_load) state_d = bfiq_pkg::SEQ_IDLE;
      default:             state_d = bfiq_pkg::SEQ_CLEAR;
    endcase
  end

  always_comb begin
    mem_ctl       = '0;
    mem_ctl.wdata = 1'b1;
    in_stall_o    = state_q != bfiq_pkg::SEQ_IDLE;
    unique case (state_q)
      bfiq_pkg::SEQ_READ:  mem_ctl.rd_en = word_ready;
      bfiq_pkg::SEQ_CHECK: mem_ctl.wr_en = (op_q == bfiq_pkg::OP_INSERT) && !rd_bit;
      default:             mem_ctl       = '{rd_en: 1'b0, wr_en: 1'b0, wdata: 1'b1};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfiq_pkg::SEQ_CLEAR;
      k_q         <= '0;
      feed_q      <= '0;
      red_q       <= '0;
      ptr_q       <= '0;
      all_hit_q   <= 1'b1;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        k_q       <= k_new;
        feed_q    <= '0;
        red_q     <= '0;
        ptr_q     <= '0;
        all_hit_q <= 1'b1;
      end else begin
        if (feed_valid) feed_q <= feed_q + 1'b1;
        if (red_valid)  red_q  <= red_q + 1'b1;
        if (state_q == bfiq_pkg::SEQ_CHECK) begin
          ptr_q     <= ptr_q + 1'b1;
          all_hit_q <= all_hit_q && rd_bit;
        end
      end
      if (mem_ctl.wr_en) count_q <= count_q + 1'b1;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= operation_i;
      for (int j = 0; j < MAX_HASHES; j++) begin
        words_q[j] <= in_words[j];
      end
    end
    if (red_valid) idx_q[red_q[SEL_W-1:0]] <= red_index;
    if (out_load) begin
      present_q <= all_hit_q;
      ones_q    <= count_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign present_o    = present_q;
  assign ones_total_o = ones_q;

endmodule

[design/bfiq_checker.sv]
// Port-level checker for the Bloom filter insert and query unit, with its bind statement.
// Depends on bfiq_pkg and the top level bloom_filter_insert_query_unit.
module bfiq_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         present_o,
  input logic [bfiq_pkg::COUNT_W-1:0] ones_total_o
);

  logic [1:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input taken in the cycle after an accepted item");

  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 2'd0)
    else $error("result shown with no item outstanding");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 2'd2)
    else $error("more than two items outstanding");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(present_o) && $stable(ones_total_o))
    else $error("stalled result changed");

endmodule

bind bloom_filter_insert_query_unit bfiq_checker u_bfiq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .present_o    (present_o),
  .ones_total_o (ones_total_o)
);

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for bloom_filter_insert_query_unit: inserts and queries, hash-count setup.
// A scoreboard class keeps its own copy of the bit array and count; needs bfiq_pkg and the DUT.
module tb;
  import bfiq_pkg::*;

  localparam int FILTER_SIZE = 65536;
  localparam int MAX_HASHES  = 5;
  localparam int RANDOM_PER_SETTING = 56;

  typedef struct packed {
    logic                               op;
    logic [NUM_WORDS-1:0][WORD_W-1:0]   words;
  } filter_item_t;

  typedef struct packed {
    logic               present;
    logic [COUNT_W-1:0] ones_total;
  } membership_result_t;

  class membership_scoreboard;
    bit                 filter_bits [FILTER_SIZE];
    logic [COUNT_W-1:0] ones_count;
    logic [CFG_W-1:0]   hash_count;
    membership_result_t expected_results [$];
    int                 errors;
    int                 inserts;
    int                 queries;
    int                 present_seen;

    function new();
      ones_count   = '0;
      hash_count   = HASH_COUNT_RST;
      errors       = 0;
      inserts      = 0;
      queries      = 0;
      present_seen = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_item(filter_item_t it);
      int unsigned        k;
      int unsigned        hits;
      int unsigned        idx;
      int                 i;
      membership_result_t res;
      k    = (hash_count > MAX_HASHES) ? MAX_HASHES : hash_count;
      hits = 0;
      for (i = 0; i < k; i++) begin
        idx = it.words[i] % FILTER_SIZE;
        if (filter_bits[idx]) begin
          hits++;
        end else if (it.op == OP_INSERT) begin
          filter_bits[idx] = 1'b1;
          ones_count++;
        end
      end
      res.present    = (hits == k);
      res.ones_total = ones_count;
      if (it.op == OP_INSERT) begin
        inserts++;
      end else begin
        queries++;
      end
      expected_results.push_back(res);
    endfunction

    function void check_result(logic present, logic [COUNT_W-1:0] ones_total);
      membership_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result present=%0d ones_total=%0d with nothing expected",
                 $time, present, ones_total);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (want.present) begin
        present_seen++;
      end
      if (present !== want.present) begin
        $display("%0t: present mismatch: expected %0d, got %0d", $time, want.present, present);
        errors++;
      end
      if (ones_total !== want.ones_total) begin
        $display("%0t: ones_total mismatch: expected %0d, got %0d",
                 $time, want.ones_total, ones_total);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [APB_AW-1:0]   paddr         = '0;
  logic [APB_DW-1:0]   pwdata        = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic                operation_i   = OP_INSERT;
  logic [WORD_W-1:0]   hash_word_0_i = '0;
  logic [WORD_W-1:0]   hash_word_1_i = '0;
  logic [WORD_W-1:0]   hash_word_2_i = '0;
  logic [WORD_W-1:0]   hash_word_3_i = '0;
  logic [WORD_W-1:0]   hash_word_4_i = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic                present_o;
  logic [COUNT_W-1:0]  ones_total_o;

  membership_scoreboard             sb;
  logic [NUM_WORDS-1:0][WORD_W-1:0] known_keys [$];
  int                               tx_idle_pct = 0;
  int                               rx_idle_pct = 0;
  int                               rx_hold     = 0;
  int unsigned                      hash_plan [9] = '{5, 1, 3, 0, 7, 6, 2, 4, 5};

  bloom_filter_insert_query_unit #(
    .FILTER_SIZE(FILTER_SIZE),
    .MAX_HASHES (MAX_HASHES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .hash_word_0_i(hash_word_0_i),
    .hash_word_1_i(hash_word_1_i),
    .hash_word_2_i(hash_word_2_i),
    .hash_word_3_i(hash_word_3_i),
    .hash_word_4_i(hash_word_4_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .present_o    (present_o),
    .ones_total_o (ones_total_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("tb: FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(present_o, ones_total_o);
    end
    if (rx_hold > 0) begin
      out_stall_i <= 1'b1;
      rx_hold = rx_hold - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  function automatic filter_item_t make_item(logic op, logic [WORD_W-1:0] w0,
                                             logic [WORD_W-1:0] w1, logic [WORD_W-1:0] w2,
                                             logic [WORD_W-1:0] w3, logic [WORD_W-1:0] w4);
    filter_item_t it;
    it.op       = op;
    it.words[0] = w0;
    it.words[1] = w1;
    it.words[2] = w2;
    it.words[3] = w3;
    it.words[4] = w4;
    return it;
  endfunction

  function automatic logic [WORD_W-1:0] fresh_word(bit narrow);
    logic [WORD_W-1:0] w;
    w = $urandom();
    if (narrow) begin
      w[15:0] = 16'($urandom_range(0, 255));
    end
    return w;
  endfunction

  // Mostly well-formed traffic: new elements, lookups and re-inserts of known ones,
  // partial overlaps, and some fully random noise.
  function automatic filter_item_t next_random_item();
    filter_item_t                     it;
    logic [NUM_WORDS-1:0][WORD_W-1:0] key;
    int                               pick;
    int                               i;
    pick = $urandom_range(0, 99);
    if (known_keys.size() == 0 && pick < 85) begin
      pick = 0;
    end
    if (pick >= 35 && pick < 85) begin
      key = known_keys[$urandom_range(0, known_keys.size() - 1)];
    end
    if (pick < 35) begin
      it.op = OP_INSERT;
      for (i = 0; i < NUM_WORDS; i++) begin
        it.words[i] = fresh_word($urandom_range(0, 3) == 0);
      end
      if (known_keys.size() >= 64) begin
        void'(known_keys.pop_front());
      end
      known_keys.push_back(it.words);
    end else if (pick < 60) begin
      it.op = OP_QUERY;
      for (i = 0; i < NUM_WORDS; i++) begin
        key[i][31:16] = 16'($urandom());
      end
      it.words = key;
    end else if (pick < 70) begin
      it.op    = OP_INSERT;
      it.words = key;
    end else if (pick < 85) begin
      it.op = ($urandom_range(0, 3) == 0) ? OP_INSERT : OP_QUERY;
      for (i = 0; i < NUM_WORDS; i++) begin
        if ($urandom_range(0, 1) == 0) begin
          key[i] = fresh_word($urandom_range(0, 1) == 0);
        end
      end
      it.words = key;
    end else begin
      it.op = 1'($urandom());
      for (i = 0; i < NUM_WORDS; i++) begin
        it.words[i] = $urandom();
      end
    end
    return it;
  endfunction

  task automatic send_item(input filter_item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= it.op;
    hash_word_0_i <= it.words[0];
    hash_word_1_i <= it.words[1];
    hash_word_2_i <= it.words[2];
    hash_word_3_i <= it.words[3];
    hash_word_4_i <= it.words[4];
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    sb.note_item(it);
  endtask

  task automatic write_hash_count(input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * int'(REG_HASH_COUNT));
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.hash_count = CFG_W'(value);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    int p;
    int n;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 23;
    rx_idle_pct = 52;
    send_item(make_item(OP_QUERY, 0, 0, 0, 0, 0));
    send_item(make_item(OP_INSERT, 0, 0, 0, 0, 0));
    send_item(make_item(OP_INSERT, 0, 0, 0, 0, 0));
    send_item(make_item(OP_QUERY, 32'hFFFF_0000, 32'h0001_0000, 32'h8000_0000, 0,
                        32'h1234_0000));
    send_item(make_item(OP_QUERY, '1, '1, '1, '1, '1));
    send_item(make_item(OP_INSERT, '1, '1, '1, '1, '1));
    send_item(make_item(OP_INSERT, 32'h0000_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                        32'h7FFF_0000, 32'hABCD_FFFF));
    send_item(make_item(OP_INSERT, 1, 2, 3, 4, 5));
    send_item(make_item(OP_QUERY, 1, 2, 3, 4, 6));
    send_item(make_item(OP_QUERY, 6, 2, 3, 4, 5));
    send_item(make_item(OP_QUERY, 32'h0001_0001, 2, 3, 4, 5));
    send_item(make_item(OP_INSERT, 5, 5, 6, 6, 7));
    send_item(make_item(OP_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333,
                        32'hCCCC_CCCC, 32'h0F0F_F0F0));
    send_item(make_item(OP_QUERY, 32'hAAAA_5555, 32'h5555_AAAA, 32'hCCCC_3333,
                        32'h3333_CCCC, 32'hF0F0_F0F0));
    in_valid_i <= 1'b0;
    wait_drained();

    for (p = 0; p < 9; p++) begin
      if (p > 0) begin
        write_hash_count(hash_plan[p]);
      end
      if (p < 3) begin
        tx_idle_pct = 23;
        rx_idle_pct = 52;
      end else if (p < 6) begin
        tx_idle_pct = 52;
        rx_idle_pct = 23;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (p == 1 || p == 6) begin
        rx_hold = 400;
      end
      for (n = 0; n < RANDOM_PER_SETTING; n++) begin
        send_item(next_random_item());
      end
      in_valid_i <= 1'b0;
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    $display("Ran %0d inserts and %0d queries over hash counts 0 to 7 and three idle mixes;",
             sb.inserts, sb.queries);
    $display("%0d results reported the element present.", sb.present_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
design/bfiq_pkg.sv
design/bfiq_mod_reduce.sv
design/bfiq_bit_store.sv
design/bloom_filter_insert_query_unit.sv
design/bfiq_checker.sv
tb/tb.sv
